// File: src/absolute_humidity_q8_8_assert.svh
// Assertion macros shared by the checker of the absolute humidity block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ABSOLUTE_HUMIDITY_Q8_8_ASSERT_SVH
`define ABSOLUTE_HUMIDITY_Q8_8_ASSERT_SVH
// Checked only while reset is low.
`define AHQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, also during reset.
`define AHQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: src/ahq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahq_pkg
// Types and constants of the absolute humidity datapath (Magnus formula).
// ----------------------------------------------------------------------------
package ahq_pkg;

  localparam int EXP_FRAC_BITS_DEF = 16;
  localparam int GUARD_BITS        = 8;
  localparam int SERIES_TERMS      = 12;
  localparam int QUEUE_DEPTH       = 4;

  localparam int TEMP_W = 15;
  localparam int RH_W   = 14;
  localparam int AH_W   = 16;

  localparam logic signed [TEMP_W-1:0] TEMP_LO = -15'sd4000;
  localparam logic signed [TEMP_W-1:0] TEMP_HI = 15'sd8500;
  localparam logic [RH_W-1:0]          RH_MAX  = 14'd10000;

  // ln(2) with 64 fraction bits.
  localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;

  // Exponent x = X_NUM_K * t / (X_DEN_K * (X_DEN_OFF + t)).
  localparam int X_NUM_K   = 1762;
  localparam int X_NUM_W   = 26;
  localparam int X_DEN_K   = 100;
  localparam int X_DEN_OFF = 24312;
  localparam int X_DEN_W   = 22;

  // 6.112 * 216.7 * 256 / 10^2 = 413897 * 128 / 15625.
  localparam int AH_NUM_K   = 413897;
  localparam int AH_NUM_W   = 19;
  localparam int AH_DEN_K   = 15625;
  localparam int AH_DEN_OFF = 27315;
  localparam int AH_DEN_W   = 30;

  // Quotient bits of the final division; one more than the result width.
  localparam int Q_BITS = AH_W + 1;

  typedef struct packed {
    logic                     oor;
    logic [RH_W-1:0]          rh;
    logic signed [TEMP_W-1:0] temp;
  } ahq_item_t;

endpackage

// File: src/ahq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahq_front
// Accepts samples, runs the validity check and queues them for the datapath.
// ----------------------------------------------------------------------------
module ahq_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ahq_pkg::TEMP_W-1:0]     temp_centi_c,
  input  logic [ahq_pkg::RH_W-1:0]       rel_hum_centi_pct,
  output logic                           q_valid,
  output ahq_pkg::ahq_item_t             q_item,
  input  logic                           q_pop
);

  localparam int PTR_W = $clog2(ahq_pkg::QUEUE_DEPTH);

  ahq_pkg::ahq_item_t mem [ahq_pkg::QUEUE_DEPTH];
  ahq_pkg::ahq_item_t in_item;
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;
  logic               push;
  logic               pop;

  always_comb begin
    in_item.temp = $signed(temp_centi_c);
    in_item.rh   = rel_hum_centi_pct;
    in_item.oor  = !(($signed(temp_centi_c) > ahq_pkg::TEMP_LO) &&
                     ($signed(temp_centi_c) < ahq_pkg::TEMP_HI) &&
                     (rel_hum_centi_pct <= ahq_pkg::RH_MAX));
  end

  assign s_tready = (count != (PTR_W + 1)'(ahq_pkg::QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign push     = s_tvalid && s_tready;
  assign pop      = q_pop && q_valid;
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_item;
  end

endmodule

// File: src/ahq_pdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahq_pdiv
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// ----------------------------------------------------------------------------
module ahq_pdiv #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int QW = 4,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [SW-1:0] out_side
);

  localparam int XW = NW + QW;

  logic          v_r [QW];
  logic [NW-1:0] r_r [QW];
  logic [DW-1:0] d_r [QW];
  logic [QW-1:0] q_r [QW];
  logic [SW-1:0] s_r [QW];

  logic [NW-1:0] pr  [QW];
  logic [DW-1:0] pd  [QW];
  logic [QW-1:0] pq  [QW];
  logic [NW-1:0] rn  [QW];
  logic [QW-1:0] qn  [QW];
  logic [XW-1:0] dsh [QW];

  // Stage i decides quotient bit QW-1-i; the quotient must fit in QW bits.
  always_comb begin
    pr[0] = num;
    pd[0] = den;
    pq[0] = '0;
    for (int i = 1; i < QW; i++) begin
      pr[i] = r_r[i-1];
      pd[i] = d_r[i-1];
      pq[i] = q_r[i-1];
    end
    for (int i = 0; i < QW; i++) begin
      dsh[i] = XW'(pd[i]) << (QW - 1 - i);
      if (XW'(pr[i]) >= dsh[i]) begin
        rn[i] = pr[i] - NW'(dsh[i]);
        qn[i] = pq[i] | (QW'(1) << (QW - 1 - i));
      end else begin
        rn[i] = pr[i];
        qn[i] = pq[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QW; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < QW; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r[0] <= side;
      for (int i = 1; i < QW; i++) s_r[i] <= s_r[i-1];
      for (int i = 0; i < QW; i++) begin
        r_r[i] <= rn[i];
        d_r[i] <= pd[i];
        q_r[i] <= qn[i];
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign quo       = q_r[QW-1];
  assign rem       = r_r[QW-1][DW-1:0];
  assign out_side  = s_r[QW-1];

endmodule

// File: src/ahq_exp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahq_exp
// Fixed-point exp(x): range reduction by ln2, Taylor series, scale by 2^k.
// ----------------------------------------------------------------------------
module ahq_exp #(
  parameter int EXP_FRAC_BITS = ahq_pkg::EXP_FRAC_BITS_DEF,
  parameter int SW            = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           in_valid,
  input  logic                           neg,
  input  logic [EXP_FRAC_BITS+ahq_pkg::GUARD_BITS+2:0] mag,
  input  logic [SW-1:0]                  side,
  output logic                           out_valid,
  output logic [EXP_FRAC_BITS+ahq_pkg::GUARD_BITS+1:0] e,
  output logic [SW-1:0]                  out_side
);

  localparam int W    = EXP_FRAC_BITS + ahq_pkg::GUARD_BITS;
  localparam int XW   = W + 3;
  localparam int XOW  = W + 4;
  localparam int SUMW = W + 2;
  localparam int SCW  = W + 9;
  localparam int EW   = W + 2;
  localparam int AW   = W + 1;
  localparam int PW   = 2 * W;
  localparam int MW   = 2 * W + 2;
  localparam int NT   = ahq_pkg::SERIES_TERMS - 1;

  localparam logic [W-1:0]    LN2  =
    W'((ahq_pkg::LN2_Q64 + (64'd1 << (63 - W))) >> (64 - W));
  localparam logic [XW-1:0]   OFF  = XW'(LN2) << 3;
  localparam logic [SUMW-1:0] ONE  = SUMW'(1) << W;
  localparam logic [PW-1:0]   HALF = PW'(1) << (W - 1);

  // Offset by 8*ln2 so that the reduction quotient is never negative.
  logic           x_v;
  logic [XOW-1:0] x_o;
  logic [SW-1:0]  x_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_v <= 1'b0;
    end else if (adv) begin
      x_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_s <= side;
      if (neg) begin
        x_o <= (mag > OFF) ? '0 : XOW'(OFF - mag);
      end else begin
        x_o <= XOW'(OFF) + XOW'(mag);
      end
    end
  end

  logic          k_v;
  logic [3:0]    k_q;
  logic [W-1:0]  k_r;
  logic [SW-1:0] k_s;

  ahq_pdiv #(
    .NW(XOW),
    .DW(W),
    .QW(4),
    .SW(SW)
  ) u_kdiv (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (x_v),
    .num       (x_o),
    .den       (LN2),
    .side      (x_s),
    .out_valid (k_v),
    .quo       (k_q),
    .rem       (k_r),
    .out_side  (k_s)
  );

  // Series chain: c[j] holds the running term and sum after j+2 terms.
  logic            c_v    [NT+1];
  logic [W-1:0]    c_r    [NT+1];
  logic [3:0]      c_k    [NT+1];
  logic [W-1:0]    c_term [NT+1];
  logic [SUMW-1:0] c_sum  [NT+1];
  logic [SW-1:0]   c_s    [NT+1];

  logic            a_v   [NT];
  logic [PW-1:0]   a_p   [NT];
  logic [W-1:0]    a_r   [NT];
  logic [3:0]      a_k   [NT];
  logic [SUMW-1:0] a_sum [NT];
  logic [SW-1:0]   a_s   [NT];

  logic            b_v   [NT];
  logic [MW-1:0]   b_m   [NT];
  logic [AW-1:0]   b_a   [NT];
  logic [W-1:0]    b_r   [NT];
  logic [3:0]      b_k   [NT];
  logic [SUMW-1:0] b_sum [NT];
  logic [SW-1:0]   b_s   [NT];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v[0] <= 1'b0;
    end else if (adv) begin
      c_v[0] <= k_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r[0]    <= k_r;
      c_k[0]    <= k_q;
      c_term[0] <= k_r;
      c_sum[0]  <= ONE + SUMW'(k_r);
      c_s[0]    <= k_s;
    end
  end

  for (genvar j = 0; j < NT; j++) begin : g_term
    localparam int unsigned N      = j + 2;
    localparam int unsigned HALF_N = N / 2;
    localparam logic [AW-1:0] RECIP = AW'((65'd1 << (W + 1)) / N);

    logic [AW-1:0] a_in;
    logic [W-1:0]  q0;
    logic [AW-1:0] rmd;
    logic [W-1:0]  qt;

    // Divide by the constant n: reciprocal estimate is low by at most one.
    assign a_in = AW'((a_p[j] + HALF) >> W) + AW'(HALF_N);
    assign q0   = W'(b_m[j] >> (W + 1));
    assign rmd  = b_a[j] - AW'(AW'(q0) * AW'(N));
    assign qt   = (rmd >= AW'(N)) ? q0 + 1'b1 : q0;

    always_ff @(posedge clk) begin
      if (rst) begin
        a_v[j]   <= 1'b0;
        b_v[j]   <= 1'b0;
        c_v[j+1] <= 1'b0;
      end else if (adv) begin
        a_v[j]   <= c_v[j];
        b_v[j]   <= a_v[j];
        c_v[j+1] <= b_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        a_p[j]      <= PW'(c_term[j]) * PW'(c_r[j]);
        a_r[j]      <= c_r[j];
        a_k[j]      <= c_k[j];
        a_sum[j]    <= c_sum[j];
        a_s[j]      <= c_s[j];
        b_m[j]      <= MW'(a_in) * MW'(RECIP);
        b_a[j]      <= a_in;
        b_r[j]      <= a_r[j];
        b_k[j]      <= a_k[j];
        b_sum[j]    <= a_sum[j];
        b_s[j]      <= a_s[j];
        c_term[j+1] <= qt;
        c_sum[j+1]  <= b_sum[j] + SUMW'(qt);
        c_r[j+1]    <= b_r[j];
        c_k[j+1]    <= b_k[j];
        c_s[j+1]    <= b_s[j];
      end
    end
  end

  logic           sc_v;
  logic [SCW-1:0] sc_val;
  logic [SW-1:0]  sc_s;
  logic [SCW-1:0] sc_next;
  logic [SCW-1:0] sc_rnd;

  // k below 8 means a rounded right shift by 8-k, otherwise a left shift by k-8.
  always_comb begin
    sc_rnd = SCW'(c_sum[NT]) + (SCW'(1) << (3'd7 - c_k[NT][2:0]));
    if (c_k[NT][3]) begin
      sc_next = SCW'(c_sum[NT]) << c_k[NT][2:0];
    end else begin
      sc_next = sc_rnd >> (4'd8 - c_k[NT]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      sc_v      <= c_v[NT];
      out_valid <= sc_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sc_val   <= sc_next;
      sc_s     <= c_s[NT];
      e        <= EW'((sc_val + (SCW'(1) << (ahq_pkg::GUARD_BITS - 1)))
                      >> ahq_pkg::GUARD_BITS);
      out_side <= sc_s;
    end
  end

endmodule

// File: src/ahq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahq_back
// Datapath: exponent division, exp, scaling product, final division, clamp.
// ----------------------------------------------------------------------------
module ahq_back #(
  parameter int EXP_FRAC_BITS = ahq_pkg::EXP_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  ahq_pkg::ahq_item_t         q_item,
  output logic                       q_pop,
  input  logic                       m_tready,
  output logic                       m_tvalid,
  output logic [ahq_pkg::AH_W-1:0]   abs_hum_q8_8,
  output logic                       saturated,
  output logic                       out_of_range
);

  localparam int W      = EXP_FRAC_BITS + ahq_pkg::GUARD_BITS;
  localparam int ITEM_W = $bits(ahq_pkg::ahq_item_t);
  localparam int XQ_W   = W + 3;
  localparam int NUM1_W = W + ahq_pkg::X_NUM_W + 1;
  localparam int EW     = W + 2;
  localparam int RHE_W  = ahq_pkg::RH_W + EW;
  localparam int PW     = RHE_W + ahq_pkg::AH_NUM_W;
  localparam int DSH    = EXP_FRAC_BITS - 7;
  localparam int DS_W   = ahq_pkg::AH_DEN_W + DSH;

  // The whole pipeline moves together unless a result waits at the output.
  logic adv;
  assign adv   = !m_tvalid || m_tready;
  assign q_pop = adv && q_valid;

  logic [ahq_pkg::TEMP_W-1:0]    mag;
  logic [ahq_pkg::X_NUM_W-1:0]   xnum;
  logic [ahq_pkg::X_DEN_W-1:0]   den1;

  always_comb begin
    mag  = q_item.temp[ahq_pkg::TEMP_W-1] ? ahq_pkg::TEMP_W'(-q_item.temp)
                                          : ahq_pkg::TEMP_W'(q_item.temp);
    xnum = ahq_pkg::X_NUM_W'(mag) * ahq_pkg::X_NUM_W'(ahq_pkg::X_NUM_K);
    den1 = ahq_pkg::X_DEN_W'(ahq_pkg::X_DEN_K *
                             (ahq_pkg::X_DEN_OFF + int'($signed(q_item.temp))));
  end

  logic                        s0_v;
  logic [NUM1_W-1:0]           s0_num;
  logic [ahq_pkg::X_DEN_W-1:0] s0_den;
  logic [ITEM_W:0]             s0_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (adv) begin
      s0_v <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_num  <= (NUM1_W'(xnum) << W) + NUM1_W'(den1 >> 1);
      s0_den  <= den1;
      s0_side <= {q_item.temp[ahq_pkg::TEMP_W-1], q_item};
    end
  end

  logic              x_v;
  logic [XQ_W-1:0]   x_mag;
  logic [ITEM_W:0]   x_side;

  ahq_pdiv #(
    .NW(NUM1_W),
    .DW(ahq_pkg::X_DEN_W),
    .QW(XQ_W),
    .SW(ITEM_W + 1)
  ) u_xdiv (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s0_v),
    .num       (s0_num),
    .den       (s0_den),
    .side      (s0_side),
    .out_valid (x_v),
    .quo       (x_mag),
    .rem       (),
    .out_side  (x_side)
  );

  logic               e_v;
  logic [EW-1:0]      e_val;
  logic [ITEM_W-1:0]  e_side;
  ahq_pkg::ahq_item_t e_item;

  ahq_exp #(
    .EXP_FRAC_BITS(EXP_FRAC_BITS),
    .SW(ITEM_W)
  ) u_exp (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (x_v),
    .neg       (x_side[ITEM_W]),
    .mag       (x_mag),
    .side      (x_side[ITEM_W-1:0]),
    .out_valid (e_v),
    .e         (e_val),
    .out_side  (e_side)
  );

  assign e_item = e_side;

  logic                         p1_v, p2_v, p3_v;
  logic [RHE_W-1:0]             p1_rhe;
  logic [ahq_pkg::AH_DEN_W-1:0] p1_den;
  ahq_pkg::ahq_item_t           p1_item, p2_item, p3_item;
  logic [PW-1:0]                p2_prod, p3_prod;
  logic [DS_W-1:0]              p2_dens, p3_dens;
  logic                         p3_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
    end else if (adv) begin
      p1_v <= e_v;
      p2_v <= p1_v;
      p3_v <= p2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_rhe  <= RHE_W'(e_item.rh) * RHE_W'(e_val);
      p1_den  <= ahq_pkg::AH_DEN_W'(ahq_pkg::AH_DEN_K *
                 (ahq_pkg::AH_DEN_OFF + int'($signed(e_item.temp))));
      p1_item <= e_item;
      p2_prod <= PW'(p1_rhe) * PW'(ahq_pkg::AH_NUM_K);
      p2_dens <= DS_W'(p1_den) << DSH;
      p2_item <= p1_item;
      p3_prod <= p2_prod;
      p3_dens <= p2_dens;
      p3_ovf  <= p2_prod >= (PW'(p2_dens) << ahq_pkg::Q_BITS);
      p3_item <= p2_item;
    end
  end

  logic                       d_v;
  logic [ahq_pkg::Q_BITS-1:0] d_q;
  logic [ITEM_W:0]            d_side;
  ahq_pkg::ahq_item_t         d_item;

  ahq_pdiv #(
    .NW(PW),
    .DW(DS_W),
    .QW(ahq_pkg::Q_BITS),
    .SW(ITEM_W + 1)
  ) u_adiv (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (p3_v),
    .num       (p3_prod),
    .den       (p3_dens),
    .side      ({p3_ovf, p3_item}),
    .out_valid (d_v),
    .quo       (d_q),
    .rem       (),
    .out_side  (d_side)
  );

  assign d_item = d_side[ITEM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (d_item.oor) begin
        abs_hum_q8_8 <= '0;
        saturated    <= 1'b0;
        out_of_range <= 1'b1;
      end else if (d_side[ITEM_W] || d_q[ahq_pkg::Q_BITS-1]) begin
        abs_hum_q8_8 <= '1;
        saturated    <= 1'b1;
        out_of_range <= 1'b0;
      end else begin
        abs_hum_q8_8 <= d_q[ahq_pkg::AH_W-1:0];
        saturated    <= 1'b0;
        out_of_range <= 1'b0;
      end
    end
  end

endmodule

// File: src/absolute_humidity_q8_8.sv
`timescale 1ns / 1ps
// Throughput: one sample per clock cycle while no result waits at the output;
// a 4-entry input queue takes requests while a result waits, until it is full.
// Reset (rst, synchronous, active high) empties the queue and all valid bits.
// ----------------------------------------------------------------------------
// absolute_humidity_q8_8
// Absolute humidity in g/m3, unsigned 8.8, from temperature and humidity.
// ----------------------------------------------------------------------------
module absolute_humidity_q8_8 #(
  parameter int EXP_FRAC_BITS = ahq_pkg::EXP_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [14:0] temp_centi_c, [28:15] rel_hum_centi_pct
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] abs_hum_q8_8
  output logic [1:0]  m_tuser    // [0] saturated, [1] out_of_range
);

  logic               q_valid;
  logic               q_pop;
  ahq_pkg::ahq_item_t q_item;

  ahq_front u_front (
    .clk               (clk),
    .rst               (rst),
    .s_tvalid          (s_tvalid),
    .s_tready          (s_tready),
    .temp_centi_c      (s_tdata[14:0]),
    .rel_hum_centi_pct (s_tdata[28:15]),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop)
  );

  ahq_back #(
    .EXP_FRAC_BITS(EXP_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .m_tready     (m_tready),
    .m_tvalid     (m_tvalid),
    .abs_hum_q8_8 (m_tdata),
    .saturated    (m_tuser[0]),
    .out_of_range (m_tuser[1])
  );

endmodule

// File: src/ahq_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahq_chk
// Port-level checks of the absolute humidity block, bound to the top level.
// ----------------------------------------------------------------------------
`include "absolute_humidity_q8_8_assert.svh"

module ahq_chk (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser
);

  `AHQ_ASSERT_ALWAYS(a_rst_clears, rst |=> !m_tvalid, "output valid after reset")

  // A rejected sample reports zero and never a clamp.
  `AHQ_ASSERT(a_oor_zero, m_tvalid && m_tuser[1] |-> m_tdata == '0 && !m_tuser[0], "oor not zero")

  `AHQ_ASSERT(a_sat_max, m_tvalid && m_tuser[0] |-> m_tdata == '1, "clamp not full scale")

  `AHQ_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "stalled result dropped")

  `AHQ_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "stall")

endmodule

bind absolute_humidity_q8_8 ahq_chk u_chk (.*);
